>>> hw/rtl/usp_pkg.sv
// ----------------------------------------------------------------------------
// usp_pkg
// Shared types, codes and character helpers of the URL splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package usp_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0] DFLT_PORT_RST = 16'd80;
	localparam logic [7:0] MAX_HOST_LEN = 8'd255;
	localparam logic [16:0] PORT_SAT = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DFLT_PORT = 2'd0,
		CFG_HTTP_ENABLE = 2'd1,
		CFG_FTP_ENABLE = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ROLE_SCHEME = 3'd0,
		ROLE_SEP = 3'd1,
		ROLE_HOST = 3'd2,
		ROLE_COLON = 3'd3,
		ROLE_PORT = 3'd4,
		ROLE_REQUEST = 3'd5,
		ROLE_REJECT = 3'd6
	} role_t;

	typedef enum logic [1:0] {
		SCH_HTTP = 2'd0,
		SCH_FTP = 2'd1,
		SCH_INVALID = 2'd2
	} scheme_t;

	function automatic logic [7:0] http_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = "h";
			3'd1: c = "t";
			3'd2: c = "t";
			3'd3: c = "p";
			3'd4: c = ":";
			3'd5: c = "/";
			3'd6: c = "/";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ftp_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = "f";
			3'd1: c = "t";
			3'd2: c = "p";
			3'd3: c = ":";
			3'd4: c = "/";
			3'd5: c = "/";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_host_char(input logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || is_digit(b)
			|| (b == "-") || (b == ".") || (b == ":") || (b == "_");
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/usp_ifs.sv
// ----------------------------------------------------------------------------
// usp_ifs
// Valid/ready channels of the URL splitter: byte input, tag output, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface usp_in_if;
	logic valid;
	logic ready;
	logic [7:0] url_byte;
	logic is_last;

	modport source (output valid, url_byte, is_last, input ready);
	modport sink (input valid, url_byte, is_last, output ready);
endinterface

interface usp_out_if;
	logic valid;
	logic ready;
	logic [2:0] byte_role;
	logic url_done;
	logic [1:0] scheme_code;
	logic accepted;
	logic [15:0] port_number;
	logic [7:0] host_length;

	modport source (output valid, byte_role, url_done, scheme_code, accepted,
		port_number, host_length, input ready);
	modport sink (input valid, byte_role, url_done, scheme_code, accepted,
		port_number, host_length, output ready);
endinterface

interface usp_cfg_if;
	logic valid;
	logic ready;
	logic [usp_pkg::CFG_IDX_W-1:0] index;
	logic [usp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/url_splitter.sv
// ----------------------------------------------------------------------------
// url_splitter
// Tags each byte of a URL and reports scheme, port and host length at its end.
// ----------------------------------------------------------------------------
// Usage:
//   url_in  : one URL word per handshake (url_byte, is_last on the final byte).
//   url_out : one result word per input word, in order; byte_role always,
//             scheme_code/accepted/port_number/host_length on url_done,
//             zero otherwise.
//   cfg     : register writes (0 fallback port, 1 http_enable, 2 ftp_enable),
//             always ready; write only while the block is idle.
// An input word passes one input register, then the tagging logic into the
// result register, before its result is offered on url_out.
// Throughput is one word per cycle while url_out does not stall; it is set by
// the per-word parse state update (prefix match, port accumulator, host count).
// When url_out stalls, the result register holds and the input register
// fills; url_in.ready drops only when both are occupied.
// Reset clears the pipeline and parse state and loads fallback port 80 and
// both scheme enables.
// ----------------------------------------------------------------------------
`default_nettype none

module url_splitter (
	input wire logic clk,
	input wire logic arst_n,
	usp_in_if.sink url_in,
	usp_out_if.source url_out,
	usp_cfg_if.sink cfg
);

	typedef enum logic [2:0] {
		PH_SCHEME = 3'd0,
		PH_HOST = 3'd1,
		PH_PORT = 3'd2,
		PH_REQUEST = 3'd3,
		PH_FTPTAIL = 3'd4,
		PH_REJECT = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		PRD_IDLE = 2'd0,
		PRD_DIGITS = 2'd1,
		PRD_DONE = 2'd2
	} port_rd_t;

	logic [15:0] dflt_port_q;
	logic http_enable_q;
	logic ftp_enable_q;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;

	logic valid_s2;
	logic [2:0] role_s2;
	logic done_s2;
	logic [1:0] scheme_s2;
	logic acc_s2;
	logic [15:0] port_s2;
	logic [7:0] host_s2;

	phase_t phase_q;
	logic [2:0] pos_q;
	logic http_live_q;
	logic ftp_live_q;
	logic [16:0] port_acc_q;
	port_rd_t port_rd_q;
	logic port_neg_q;
	logic [7:0] host_cnt_q;

	phase_t phase_nxt;
	logic [2:0] pos_nxt;
	logic http_live_nxt;
	logic ftp_live_nxt;
	logic [16:0] port_acc_nxt;
	port_rd_t port_rd_nxt;
	logic port_neg_nxt;
	logic [7:0] host_cnt_nxt;

	usp_pkg::role_t role_c;
	usp_pkg::scheme_t scheme_c;
	logic acc_c;
	logic [15:0] port_c;
	logic [7:0] lower_c;
	logic h_c;
	logic f_c;
	logic [20:0] port_mul_c;

	logic move;

	assign move = valid_s1 && (!valid_s2 || url_out.ready);
	assign url_in.ready = !valid_s1 || move;
	assign cfg.ready = 1'b1;

	assign url_out.valid = valid_s2;
	assign url_out.byte_role = role_s2;
	assign url_out.url_done = done_s2;
	assign url_out.scheme_code = scheme_s2;
	assign url_out.accepted = acc_s2;
	assign url_out.port_number = port_s2;
	assign url_out.host_length = host_s2;

	always_comb begin
		role_c = usp_pkg::ROLE_REJECT;
		phase_nxt = phase_q;
		pos_nxt = pos_q;
		http_live_nxt = http_live_q;
		ftp_live_nxt = ftp_live_q;
		port_acc_nxt = port_acc_q;
		port_rd_nxt = port_rd_q;
		port_neg_nxt = port_neg_q;
		host_cnt_nxt = host_cnt_q;
		lower_c = usp_pkg::to_lower(byte_s1);
		h_c = http_live_q && (pos_q < 3'd7) && (lower_c == usp_pkg::http_char(pos_q));
		f_c = ftp_live_q && (pos_q < 3'd6) && (lower_c == usp_pkg::ftp_char(pos_q));
		port_mul_c = {1'b0, port_acc_q, 3'b000} + {3'b000, port_acc_q, 1'b0}
			+ {13'd0, byte_s1 - 8'd48};

		unique case (phase_q) inside
			PH_SCHEME: begin
				http_live_nxt = h_c;
				ftp_live_nxt = f_c;
				if (h_c || f_c) begin
					role_c = ((byte_s1 == ":") || (byte_s1 == "/")) ?
						usp_pkg::ROLE_SEP : usp_pkg::ROLE_SCHEME;
					if (h_c && (pos_q == 3'd6))
						phase_nxt = http_enable_q ? PH_HOST : PH_REJECT;
					else if (f_c && (pos_q == 3'd5))
						phase_nxt = ftp_enable_q ? PH_FTPTAIL : PH_REJECT;
				end else begin
					phase_nxt = PH_REJECT;
				end
				if (pos_q < 3'd7)
					pos_nxt = pos_q + 3'd1;
			end
			PH_HOST, PH_PORT: begin
				if (!usp_pkg::is_host_char(byte_s1)) begin
					phase_nxt = PH_REQUEST;
					role_c = usp_pkg::ROLE_REQUEST;
				end else if (phase_q == PH_HOST) begin
					if (byte_s1 == ":") begin
						phase_nxt = PH_PORT;
						role_c = usp_pkg::ROLE_COLON;
					end else begin
						role_c = usp_pkg::ROLE_HOST;
						if (host_cnt_q < usp_pkg::MAX_HOST_LEN)
							host_cnt_nxt = host_cnt_q + 8'd1;
					end
				end else begin
					role_c = usp_pkg::ROLE_PORT;
					if ((port_rd_q == PRD_IDLE) && (byte_s1 == "-")) begin
						port_neg_nxt = 1'b1;
						port_rd_nxt = PRD_DIGITS;
					end else if ((port_rd_q != PRD_DONE) && usp_pkg::is_digit(byte_s1)) begin
						port_acc_nxt = (port_mul_c > {4'd0, usp_pkg::PORT_SAT}) ?
							usp_pkg::PORT_SAT : port_mul_c[16:0];
						port_rd_nxt = PRD_DIGITS;
					end else begin
						port_rd_nxt = PRD_DONE;
					end
				end
			end
			PH_REQUEST: role_c = usp_pkg::ROLE_REQUEST;
			default: role_c = usp_pkg::ROLE_REJECT;
		endcase

		acc_c = (phase_nxt == PH_HOST) || (phase_nxt == PH_PORT) || (phase_nxt == PH_REQUEST);
		if (acc_c)
			scheme_c = usp_pkg::SCH_HTTP;
		else if (phase_nxt == PH_FTPTAIL)
			scheme_c = usp_pkg::SCH_FTP;
		else
			scheme_c = usp_pkg::SCH_INVALID;
		port_c = dflt_port_q;
		if (acc_c && !port_neg_nxt && (port_acc_nxt != 17'd0))
			port_c = port_acc_nxt[16] ? 16'hFFFF : port_acc_nxt[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_port_q <= usp_pkg::DFLT_PORT_RST;
			http_enable_q <= 1'b1;
			ftp_enable_q <= 1'b1;
			valid_s1 <= 1'b0;
			byte_s1 <= '0;
			last_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			role_s2 <= '0;
			done_s2 <= 1'b0;
			scheme_s2 <= '0;
			acc_s2 <= 1'b0;
			port_s2 <= '0;
			host_s2 <= '0;
			phase_q <= PH_SCHEME;
			pos_q <= 3'd0;
			http_live_q <= 1'b1;
			ftp_live_q <= 1'b1;
			port_acc_q <= 17'd0;
			port_rd_q <= PRD_IDLE;
			port_neg_q <= 1'b0;
			host_cnt_q <= 8'd0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					usp_pkg::CFG_DFLT_PORT: dflt_port_q <= cfg.data;
					usp_pkg::CFG_HTTP_ENABLE: http_enable_q <= cfg.data[0];
					usp_pkg::CFG_FTP_ENABLE: ftp_enable_q <= cfg.data[0];
					default: ;
				endcase
			end

			if (url_in.valid && url_in.ready)
				valid_s1 <= 1'b1;
			else if (move)
				valid_s1 <= 1'b0;

			if (url_in.valid && url_in.ready) begin
				byte_s1 <= url_in.url_byte;
				last_s1 <= url_in.is_last;
			end

			if (move)
				valid_s2 <= 1'b1;
			else if (url_out.ready)
				valid_s2 <= 1'b0;

			if (move) begin
				role_s2 <= role_c;
				done_s2 <= last_s1;
				scheme_s2 <= last_s1 ? scheme_c : 2'd0;
				acc_s2 <= last_s1 && acc_c;
				port_s2 <= last_s1 ? port_c : 16'd0;
				host_s2 <= (last_s1 && acc_c) ? host_cnt_nxt : 8'd0;
				if (last_s1) begin
					phase_q <= PH_SCHEME;
					pos_q <= 3'd0;
					http_live_q <= 1'b1;
					ftp_live_q <= 1'b1;
					port_acc_q <= 17'd0;
					port_rd_q <= PRD_IDLE;
					port_neg_q <= 1'b0;
					host_cnt_q <= 8'd0;
				end else begin
					phase_q <= phase_nxt;
					pos_q <= pos_nxt;
					http_live_q <= http_live_nxt;
					ftp_live_q <= ftp_live_nxt;
					port_acc_q <= port_acc_nxt;
					port_rd_q <= port_rd_nxt;
					port_neg_q <= port_neg_nxt;
					host_cnt_q <= host_cnt_nxt;
				end
			end
		end
	end

	a_accept_http: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && acc_s2) |-> (scheme_s2 == usp_pkg::SCH_HTTP))
		else $error("accepted result without http scheme");

	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !done_s2) |-> (port_s2 == 16'd0 && host_s2 == 8'd0 && !acc_s2))
		else $error("summary fields set on a result that is not the last");

	a_host_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && host_s2 != 8'd0) |-> acc_s2)
		else $error("host length reported for a rejected URL");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(move && last_s1) |=> (phase_q == PH_SCHEME && pos_q == 3'd0 && host_cnt_q == 8'd0))
		else $error("parse state not cleared after last byte");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !url_out.ready) |=> (valid_s2 && $stable(role_s2) && $stable(port_s2)))
		else $error("result changed while stalled");

endmodule

`default_nettype wire
